>>> rtl/core/bounded_priority_queue_macros.svh
// Assertion macros used by the bounded priority queue top level.
`ifndef BOUNDED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpq assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpq assertion failed");

`endif

>>> rtl/core/bpq_pkg.sv
// Package: sizes, codes and types of the bounded priority queue.
`timescale 1ns / 1ps
package bpq_pkg;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TAG_BITS      = 16;
    localparam int LIM_W         = 5;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int CMP_W         = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam logic [LIM_W-1:0] CAP_RESET = LIM_W'(16);

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXTRACTED = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [TAG_BITS-1:0]      tag;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic ext;
        logic occ;
    } t_cell_ctl;

endpackage

>>> rtl/core/bpq_if.sv
// Valid/ready channel interfaces for the queue request and result words.
`timescale 1ns / 1ps
interface bpq_in_if;
    import bpq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]      tag;
    modport source (output valid, kind, priority_req, tag, input ready);
    modport sink (input valid, kind, priority_req, tag, output ready);
endinterface

interface bpq_out_if;
    import bpq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [TAG_BITS-1:0]      out_tag;
    modport source (output valid, status, out_priority, out_tag, input ready);
    modport sink (input valid, status, out_priority, out_tag, output ready);
endinterface

>>> rtl/core/bounded_priority_queue.sv
// Bounded priority queue with extract-max: top level over a chain of sorted cells.
//
// Usage: each request word on i_in is an insert (kind 0, priority and tag)
// or an extract (kind 1). Every request yields exactly one result word on
// o_out: inserted, rejected full, extracted (with priority and tag) or
// empty. Entries are held sorted by priority, ties in arrival order, in a
// row of cells; each cell compares only with the broadcast new word and its
// neighbors, so every request finishes in the cycle it is accepted.
// The result is registered and appears in the cycle after acceptance. Throughput: one
// word per cycle while o_out.ready is high. When the receiver stalls the
// result is held in the output register and i_in.ready drops until it is
// taken; a new word is accepted in the same cycle the held one leaves.
// i_cfg_we with i_cfg_wdata sets the capacity limit (saturating at the
// chain depth); write it only while no result is pending.
// Reset (synchronous, active low) empties the queue, clears the output
// valid and restores the capacity limit to 16. No clearing pass is needed.
`timescale 1ns / 1ps
module bounded_priority_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    bpq_in_if.sink                  i_in,
    bpq_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [bpq_pkg::LIM_W-1:0] i_cfg_wdata
);
    import bpq_pkg::*;
    `include "bounded_priority_queue_macros.svh"

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [LIM_W-1:0] r_limit;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [1:0]       r_out_status;
    t_entry           r_out_entry;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             do_ins;
    logic             do_ext;
    logic [CMP_W-1:0] lim_x;
    logic [CMP_W-1:0] eff_lim;
    t_entry           new_entry;

    t_entry           cell_q    [DEPTH];
    t_entry           cell_left [DEPTH];
    t_entry           cell_right[DEPTH];
    logic             cell_keep [DEPTH];
    logic             left_keep [DEPTH];
    t_cell_ctl        cell_ctl  [DEPTH];

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_rst_n && (!r_out_valid || o_out.ready);
    assign new_entry   = '{prio: i_in.priority_req, tag: i_in.tag};

    assign lim_x    = CMP_W'(r_limit);
    assign eff_lim  = (lim_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_x;
    assign is_full  = CMP_W'(r_count) >= eff_lim;
    assign is_empty = (r_count == '0);
    assign do_ins   = accept && (i_in.kind == KIND_INSERT) && !is_full;
    assign do_ext   = accept && (i_in.kind == KIND_EXTRACT) && !is_empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            assign cell_ctl[gi] = '{ins: do_ins, ext: do_ext, occ: (IDX < r_count)};
            if (gi == 0) begin : g_head
                assign cell_left[gi] = new_entry;
                assign left_keep[gi] = 1'b1;
            end else begin : g_body
                assign cell_left[gi] = cell_q[gi-1];
                assign left_keep[gi] = cell_keep[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign cell_right[gi] = cell_q[gi];
            end else begin : g_inner
                assign cell_right[gi] = cell_q[gi+1];
            end
            bpq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[gi]),
                .i_new       (new_entry),
                .i_left      (cell_left[gi]),
                .i_left_keep (left_keep[gi]),
                .i_right     (cell_right[gi]),
                .o_keep      (cell_keep[gi]),
                .o_entry     (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_ext) begin
            n_count = r_count - 1'b1;
        end
        n_out_valid = accept ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in.kind == KIND_INSERT) begin
                r_out_status <= is_full ? ST_FULL : ST_INSERTED;
                r_out_entry  <= '0;
            end else if (is_empty) begin
                r_out_status <= ST_EMPTY;
                r_out_entry  <= '0;
            end else begin
                r_out_status <= ST_EXTRACTED;
                r_out_entry  <= cell_q[0];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.out_priority = r_out_entry.prio;
    assign o_out.out_tag      = r_out_entry.tag;

    `BPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `BPQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, do_ins, r_count == CNT_W'($past(r_count) + 1'b1))
    `BPQ_ASSERT_NEXT(a_ext_status, i_clk, i_rst_n, do_ext, r_out_valid && (r_out_status == ST_EXTRACTED))
    `BPQ_ASSERT_NOW(a_head_sorted, i_clk, i_rst_n, r_count >= CNT_W'(2), cell_q[0].prio >= cell_q[1].prio)

endmodule

>>> rtl/core/bpq_cell.sv
// One slot of the sorted entry chain: keeps, takes the new word, or shifts.
`timescale 1ns / 1ps
module bpq_cell (
    input  logic               i_clk,
    input  bpq_pkg::t_cell_ctl i_ctl,
    input  bpq_pkg::t_entry    i_new,
    input  bpq_pkg::t_entry    i_left,
    input  logic               i_left_keep,
    input  bpq_pkg::t_entry    i_right,
    output logic               o_keep,
    output bpq_pkg::t_entry    o_entry
);
    import bpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // equal priorities stay ahead of the new word: earliest wins ties
    assign o_keep  = i_ctl.occ && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_new : i_left;
            end
        end else if (i_ctl.ext) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
